### hw/rtl/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg: shared types and constants of the fingerprint command framer
// Transaction payload structs, action and result kind codes, the burst
// descriptor that passes from the framing core to the result serializer.
// ----------------------------------------------------------------------------
package fcf_pkg;

    // Largest payload or reply data length; longer requests saturate here
    localparam int PAYLOAD_MAX  = 32;
    localparam int LEN_W        = 6;
    // Longest result burst: ten header bytes plus two checksum bytes
    localparam int BURST_MAX    = 12;
    localparam int BURST_IDX_W  = $clog2(BURST_MAX);
    localparam int BURST_CNT_W  = $clog2(BURST_MAX + 1);

    // Frame bytes
    localparam logic [7:0] START_HI  = 8'hEF;
    localparam logic [7:0] START_LO  = 8'h01;
    localparam logic [7:0] PACKET_ID = 8'h01;

    // Reply layout
    localparam logic [LEN_W-1:0] RX_POS_LEN_HI = 6'd7;
    localparam logic [LEN_W-1:0] RX_POS_LEN_LO = 6'd8;
    localparam logic [LEN_W-1:0] RX_POS_CONF   = 6'd9;
    localparam logic [LEN_W-1:0] RX_POS_DATA   = 6'd10;
    localparam logic [LEN_W-1:0] RX_FRAME_OVH  = 6'd11;
    localparam logic [15:0]      LEN_OVH       = 16'd3;

    // Action codes
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_PAYLOAD = 2'd1;
    localparam logic [1:0] ACT_RX      = 2'd2;

    // Result kind codes
    localparam logic [1:0] KIND_TX        = 2'd0;
    localparam logic [1:0] KIND_RX_DATA   = 2'd1;
    localparam logic [1:0] KIND_RX_STATUS = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [7:0]       cmd_code;
        logic [LEN_W-1:0] payload_len;
        logic [LEN_W-1:0] expected_reply_len;
        logic [7:0]       data_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        last;
        logic [7:0]  confirm_code;
        logic [15:0] reply_len;
        logic        reply_ok;
        logic        reply_too_long;
    } t_result;

    // Results caused by one transaction, in compact form
    typedef struct packed {
        logic [BURST_CNT_W-1:0]         count;
        logic                           is_rx;
        logic                           chk;
        logic [BURST_MAX-1:0][7:0]      tx_bytes;
        logic [1:0]                     rx_res_unused;
        t_result [1:0]                  rx_res;
    } t_burst;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
        return (v > LEN_W'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX) : v;
    endfunction

endpackage

### hw/rtl/fcf_core.sv
// ----------------------------------------------------------------------------
// fcf_core: framing and parsing state
// Holds the transmit checksum and byte count, the reply position and the
// captured reply header, and turns one accepted transaction into a burst
// descriptor in a single pass.
// ----------------------------------------------------------------------------
module fcf_core import fcf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_accept,
    input  t_item       i_item,
    output t_burst      o_burst
);

    logic [31:0]      r_addr;
    logic [15:0]      r_tx_sum,  n_tx_sum;
    logic [LEN_W-1:0] r_tx_rem,  n_tx_rem;
    logic [LEN_W-1:0] r_rx_pos,  n_rx_pos;
    logic [LEN_W-1:0] r_rx_exp,  n_rx_exp;
    logic [15:0]      r_rx_len,  n_rx_len;
    logic [7:0]       r_rx_conf, n_rx_conf;

    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] elen;
    logic [15:0]      tx_len;
    logic [15:0]      hdr_sum;
    logic [15:0]      pay_sum;
    logic [LEN_W-1:0] pay_rem;
    logic [LEN_W-1:0] frame_end;
    logic [15:0]      rx_off;
    logic             len_ge3;
    logic             too_long;
    logic [15:0]      copy;
    logic             rx_data;
    logic             rx_end;
    t_result          data_res;
    t_result          stat_res;

    // Shared arithmetic for the three actions
    always_comb begin
        plen      = sat_len(i_item.payload_len);
        elen      = sat_len(i_item.expected_reply_len);
        tx_len    = {{(16-LEN_W){1'b0}}, plen} + LEN_OVH;
        hdr_sum   = {8'd0, PACKET_ID} + {8'd0, tx_len[15:8]} + {8'd0, tx_len[7:0]}
                  + {8'd0, i_item.cmd_code};
        pay_sum   = r_tx_sum + {8'd0, i_item.data_byte};
        pay_rem   = r_tx_rem - LEN_W'(1);
        frame_end = RX_FRAME_OVH + r_rx_exp;
        rx_off    = {{(16-LEN_W){1'b0}}, r_rx_pos} - {{(16-LEN_W){1'b0}}, RX_POS_DATA};
        len_ge3   = (r_rx_len >= LEN_OVH);
        too_long  = len_ge3 && ((r_rx_len - LEN_OVH) > {{(16-LEN_W){1'b0}}, r_rx_exp});
        copy      = (len_ge3 && !too_long) ? (r_rx_len - LEN_OVH) : 16'd0;
        rx_data   = (r_rx_pos >= RX_POS_DATA) && (rx_off < copy);
        rx_end    = (r_rx_pos >= frame_end);

        data_res                = '0;
        data_res.kind           = KIND_RX_DATA;
        data_res.out_byte       = i_item.data_byte;
        data_res.last           = (rx_off == (copy - 16'd1));
        data_res.confirm_code   = r_rx_conf;
        data_res.reply_len      = r_rx_len;

        stat_res                = '0;
        stat_res.kind           = KIND_RX_STATUS;
        stat_res.last           = 1'b1;
        stat_res.confirm_code   = r_rx_conf;
        stat_res.reply_len      = r_rx_len;
        stat_res.reply_ok       = (r_rx_conf == 8'd0) && !too_long;
        stat_res.reply_too_long = too_long;
    end

    // Next state and burst for the current transaction
    always_comb begin
        n_tx_sum  = r_tx_sum;
        n_tx_rem  = r_tx_rem;
        n_rx_pos  = r_rx_pos;
        n_rx_exp  = r_rx_exp;
        n_rx_len  = r_rx_len;
        n_rx_conf = r_rx_conf;
        o_burst   = '0;
        case (i_item.action)
            ACT_START: begin
                o_burst.tx_bytes[0]  = START_HI;
                o_burst.tx_bytes[1]  = START_LO;
                o_burst.tx_bytes[2]  = r_addr[31:24];
                o_burst.tx_bytes[3]  = r_addr[23:16];
                o_burst.tx_bytes[4]  = r_addr[15:8];
                o_burst.tx_bytes[5]  = r_addr[7:0];
                o_burst.tx_bytes[6]  = PACKET_ID;
                o_burst.tx_bytes[7]  = tx_len[15:8];
                o_burst.tx_bytes[8]  = tx_len[7:0];
                o_burst.tx_bytes[9]  = i_item.cmd_code;
                o_burst.tx_bytes[10] = hdr_sum[15:8];
                o_burst.tx_bytes[11] = hdr_sum[7:0];
                o_burst.chk          = (plen == '0);
                o_burst.count        = (plen == '0) ? BURST_CNT_W'(BURST_MAX)
                                                    : BURST_CNT_W'(BURST_MAX - 2);
                n_tx_sum  = hdr_sum;
                n_tx_rem  = plen;
                n_rx_pos  = '0;
                n_rx_exp  = elen;
                n_rx_len  = '0;
                n_rx_conf = '0;
            end
            ACT_PAYLOAD: begin
                if (r_tx_rem != '0) begin
                    n_tx_sum             = pay_sum;
                    n_tx_rem             = pay_rem;
                    o_burst.tx_bytes[0]  = i_item.data_byte;
                    o_burst.tx_bytes[1]  = pay_sum[15:8];
                    o_burst.tx_bytes[2]  = pay_sum[7:0];
                    o_burst.chk          = (pay_rem == '0);
                    o_burst.count        = (pay_rem == '0) ? BURST_CNT_W'(3)
                                                           : BURST_CNT_W'(1);
                end
            end
            ACT_RX: begin
                o_burst.is_rx = 1'b1;
                if (r_rx_pos == RX_POS_LEN_HI) begin
                    n_rx_len = {i_item.data_byte, r_rx_len[7:0]};
                end else if (r_rx_pos == RX_POS_LEN_LO) begin
                    n_rx_len = {r_rx_len[15:8], i_item.data_byte};
                end else if (r_rx_pos == RX_POS_CONF) begin
                    n_rx_conf = i_item.data_byte;
                end
                // Data result first, then the status result at frame end
                if (rx_data) begin
                    o_burst.rx_res[0] = data_res;
                    o_burst.rx_res[1] = stat_res;
                end else begin
                    o_burst.rx_res[0] = stat_res;
                end
                o_burst.count = BURST_CNT_W'({1'b0, rx_data} + {1'b0, rx_end});
                n_rx_pos      = rx_end ? '0 : (r_rx_pos + LEN_W'(1));
            end
            default: begin
                o_burst = '0;
            end
        endcase
    end

    // Hold the address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            r_addr <= i_cfg_wdata;
        end
    end

    // Advance the state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_sum  <= '0;
            r_tx_rem  <= '0;
            r_rx_pos  <= '0;
            r_rx_exp  <= '0;
            r_rx_len  <= '0;
            r_rx_conf <= '0;
        end else if (i_accept) begin
            r_tx_sum  <= n_tx_sum;
            r_tx_rem  <= n_tx_rem;
            r_rx_pos  <= n_rx_pos;
            r_rx_exp  <= n_rx_exp;
            r_rx_len  <= n_rx_len;
            r_rx_conf <= n_rx_conf;
        end
    end

endmodule

### hw/rtl/fcf_burst.sv
// ----------------------------------------------------------------------------
// fcf_burst: result serializer
// Holds one burst descriptor and moves its results one per cycle into the
// output register while that register is free or being read. Takes the next
// descriptor in the cycle that the last result of the current one leaves.
// ----------------------------------------------------------------------------
module fcf_burst import fcf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_burst  i_burst,
    output logic    o_load_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    t_burst                 r_desc;
    logic                   r_busy;
    logic [BURST_IDX_W-1:0] r_idx;
    logic                   r_out_valid;
    t_result                r_out;

    logic    slot_free;
    logic    move;
    logic    final_move;
    t_result cur;

    // Select the result at the current burst position
    always_comb begin
        cur = '0;
        if (r_desc.is_rx) begin
            cur = r_desc.rx_res[r_idx[0]];
        end else begin
            cur.kind     = KIND_TX;
            cur.out_byte = r_desc.tx_bytes[r_idx];
            cur.last     = r_desc.chk
                         && (BURST_CNT_W'(r_idx) == (r_desc.count - BURST_CNT_W'(1)));
        end
    end

    assign slot_free    = !r_out_valid || i_out_ready;
    assign move         = r_busy && slot_free;
    assign final_move   = move
                        && (BURST_CNT_W'(r_idx) == (r_desc.count - BURST_CNT_W'(1)));
    assign o_load_ready = !r_busy || final_move;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    // Advance the burst position and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= (i_burst.count != '0);
                r_idx  <= '0;
            end else if (move) begin
                r_busy <= !final_move;
                r_idx  <= r_idx + BURST_IDX_W'(1);
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the descriptor and the output payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_burst;
        end
        if (move) begin
            r_out <= cur;
        end
    end

    // A live burst never points past its last result
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (BURST_CNT_W'(r_idx) < r_desc.count))
        else $error("burst position beyond burst length");

    // A load is only taken when the previous burst is done
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && r_busy) |-> final_move)
        else $error("burst loaded over unfinished burst");

    // Every status result closes the reply
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_RX_STATUS)) |-> r_out.last)
        else $error("status result without last");

    // A moved result shows up in the output register next cycle
    a_move_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_valid)
        else $error("moved result not presented");

endmodule

### hw/rtl/fingerprint_command_framer.sv
// ----------------------------------------------------------------------------
// fingerprint_command_framer: command packet builder and reply parser
// Builds sensor command packets from start and payload transactions and
// parses received reply bytes into data and status results.
// ----------------------------------------------------------------------------
// Each input transaction is turned into a burst descriptor and produces zero, one
// or more results, which leave one per cycle, while the output is not stalled,
// through a registered output stage. A start transaction produces 10 results (12
// when the payload length is zero), the last payload byte 3 (byte plus checksum),
// a received byte 0 to 2; other transactions produce at most one. The input is
// ready again in the cycle the last result of the previous transaction moves to
// the output register, so with single-result traffic and no output stall one
// transaction is accepted every cycle; the output channel paces header and
// checksum bursts. An accepted transaction is first registered as a burst
// descriptor, from which its first result moves into the free output register.
// The module address is written through i_cfg_we / i_cfg_wdata and resets to
// all ones.
// ----------------------------------------------------------------------------
module fingerprint_command_framer import fcf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_item       i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out_data
);

    logic   accept;
    t_burst burst;

    assign accept = i_in_valid && o_in_ready;

    // Framing and parsing state
    fcf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_item      (i_in_data),
        .o_burst     (burst)
    );

    // Result serializer and output register
    fcf_burst u_burst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_burst      (burst),
        .o_load_ready (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

### sim/fcf_frame_check.sv
// ----------------------------------------------------------------------------
// fcf_frame_check: result predictor and comparator for the command framer
// Watches the configuration port and both transaction channels, builds the
// packet and reply results each accepted input should cause, and compares
// every accepted output against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fcf_frame_check import fcf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_item       i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_result     i_out_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // Predicted framer state
    logic [31:0]      frame_addr;
    logic [15:0]      tx_sum_acc;
    logic [LEN_W-1:0] tx_left;
    logic [LEN_W-1:0] rx_pos;
    logic [LEN_W-1:0] rx_data_max;
    logic [15:0]      rx_len_word;
    logic [7:0]       rx_conf;

    t_result due_results[$];
    int      fail_total;
    int      checked_total;
    bit      field_bad;

    function automatic void push_tx_byte(input logic [7:0] value, input logic is_last);
        t_result r;
        r = '0;
        r.kind     = KIND_TX;
        r.out_byte = value;
        r.last     = is_last;
        due_results.push_back(r);
    endfunction

    // Send the running sum high byte first, closing the packet
    function automatic void push_checksum();
        push_tx_byte(tx_sum_acc[15:8], 1'b0);
        push_tx_byte(tx_sum_acc[7:0], 1'b1);
    endfunction

    function automatic void frame_transaction(input t_item it);
        int          plen;
        int          elen;
        int          p;
        int          frame_end;
        int          len;
        int          copy_cnt;
        int          i;
        bit          too_long;
        logic [15:0] hdr_len;
        t_result     r;

        plen = (it.payload_len > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(it.payload_len);
        elen = (it.expected_reply_len > PAYLOAD_MAX) ? PAYLOAD_MAX
                                                     : int'(it.expected_reply_len);
        case (it.action)
            ACT_START: begin
                // Emit the header and restart both directions
                hdr_len = 16'(plen) + LEN_OVH;
                push_tx_byte(START_HI, 1'b0);
                push_tx_byte(START_LO, 1'b0);
                for (i = 3; i >= 0; i--) begin
                    push_tx_byte(frame_addr[8*i +: 8], 1'b0);
                end
                push_tx_byte(PACKET_ID, 1'b0);
                push_tx_byte(hdr_len[15:8], 1'b0);
                push_tx_byte(hdr_len[7:0], 1'b0);
                push_tx_byte(it.cmd_code, 1'b0);
                tx_sum_acc = 16'(PACKET_ID) + 16'(hdr_len[15:8]) + 16'(hdr_len[7:0])
                           + 16'(it.cmd_code);
                tx_left = LEN_W'(plen);
                if (plen == 0) begin
                    push_checksum();
                end
                rx_pos      = '0;
                rx_data_max = LEN_W'(elen);
                rx_len_word = '0;
                rx_conf     = '0;
            end
            ACT_PAYLOAD: begin
                // Drop payload bytes when nothing is outstanding
                if (tx_left != 0) begin
                    tx_left    = tx_left - 1'b1;
                    tx_sum_acc = tx_sum_acc + 16'(it.data_byte);
                    push_tx_byte(it.data_byte, 1'b0);
                    if (tx_left == 0) begin
                        push_checksum();
                    end
                end
            end
            ACT_RX: begin
                p         = rx_pos;
                frame_end = RX_FRAME_OVH + rx_data_max;
                len       = rx_len_word;
                too_long  = (len >= LEN_OVH) && ((len - LEN_OVH) > rx_data_max);
                copy_cnt  = (len >= LEN_OVH && !too_long) ? len - LEN_OVH : 0;

                // Capture length and confirmation, pass reply data through
                if (p == RX_POS_LEN_HI) begin
                    rx_len_word[15:8] = it.data_byte;
                end else if (p == RX_POS_LEN_LO) begin
                    rx_len_word[7:0] = it.data_byte;
                end else if (p == RX_POS_CONF) begin
                    rx_conf = it.data_byte;
                end else if (p >= RX_POS_DATA && (p - RX_POS_DATA) < copy_cnt) begin
                    r = '0;
                    r.kind         = KIND_RX_DATA;
                    r.out_byte     = it.data_byte;
                    r.last         = ((p - RX_POS_DATA) == copy_cnt - 1);
                    r.confirm_code = rx_conf;
                    r.reply_len    = rx_len_word;
                    due_results.push_back(r);
                end

                // Close the frame with a status result
                if (p >= frame_end) begin
                    r = '0;
                    r.kind           = KIND_RX_STATUS;
                    r.last           = 1'b1;
                    r.confirm_code   = rx_conf;
                    r.reply_len      = rx_len_word;
                    r.reply_ok       = (rx_conf == 0) && !too_long;
                    r.reply_too_long = too_long;
                    due_results.push_back(r);
                    rx_pos = '0;
                end else begin
                    rx_pos = LEN_W'(p + 1);
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] want, got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            field_bad = 1'b1;
        end
    endtask

    task automatic compare_result(input t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected result: kind %0d byte 0x%0h last %0b",
                     $time, got.kind, got.out_byte, got.last);
            fail_total++;
        end else begin
            want      = due_results.pop_front();
            field_bad = 1'b0;
            check_field("kind", 16'(want.kind), 16'(got.kind));
            check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
            check_field("last", 16'(want.last), 16'(got.last));
            check_field("confirm_code", 16'(want.confirm_code), 16'(got.confirm_code));
            check_field("reply_len", want.reply_len, got.reply_len);
            check_field("reply_ok", 16'(want.reply_ok), 16'(got.reply_ok));
            check_field("reply_too_long", 16'(want.reply_too_long),
                        16'(got.reply_too_long));
            if (field_bad) begin
                fail_total++;
            end
            checked_total++;
        end
    endtask

    initial begin
        fail_total    = 0;
        checked_total = 0;
        o_fail_count  = 0;
        o_pending     = 0;
        o_checked     = 0;
    end

    // Compare outputs, track config, predict inputs on each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_addr  = '1;
            tx_sum_acc  = '0;
            tx_left     = '0;
            rx_pos      = '0;
            rx_data_max = '0;
            rx_len_word = '0;
            rx_conf     = '0;
            due_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_result(i_out_data);
            end
            if (i_cfg_we) begin
                frame_addr = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                frame_transaction(i_in_data);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= due_results.size();
        o_checked    <= checked_total;
    end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the fingerprint command framer
// Drives command, payload and reply byte transactions with bursty input and
// a patterned output stall, rewrites the module address between phases, and
// reports the verdict from the frame checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
    import fcf_pkg::*;

    localparam int         IDLE_LIMIT    = 200;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         TAIL_CYCLES   = 6;
    localparam int         ITEM_TARGET   = 260;
    localparam int         PHASES        = 4;
    localparam logic [1:0] ACT_UNUSED    = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_item       in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_result     out_data;

    int          fail_count;
    int          pending;
    int          checked;
    int          idle_cycles  = 0;
    int          burst_left   = 0;
    int          items_sent   = 0;
    int          addr_writes  = 0;
    int          action_count[4];
    logic [7:0]  ready_mask   = 8'hFF;
    int          mask_age     = 0;

    // Clock, period 20
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    fingerprint_command_framer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    fcf_frame_check u_frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Stall the result channel on a rotating mask, reshuffled now and then
    always @(posedge clk) begin
        if (mask_age == 39) begin
            mask_age <= 0;
            if ($urandom_range(0, 2) == 0) begin
                ready_mask <= 8'hFF;
            end else begin
                ready_mask <= 8'($urandom_range(1, 255));
            end
        end else begin
            mask_age   <= mask_age + 1;
            ready_mask <= {ready_mask[6:0], ready_mask[7]};
        end
        out_ready <= ready_mask[0];
    end

    // Abort when no transaction moves for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_item noise_item();
        t_item it;
        it.action             = 2'($urandom);
        it.cmd_code           = 8'($urandom);
        it.payload_len        = LEN_W'($urandom);
        it.expected_reply_len = LEN_W'($urandom);
        it.data_byte          = 8'($urandom);
        return it;
    endfunction

    // Unused fields keep random content
    function automatic t_item item_with(input logic [1:0] act, input logic [7:0] value);
        t_item it;
        it           = noise_item();
        it.action    = act;
        it.data_byte = value;
        return it;
    endfunction

    // Mostly short lengths, some up to the limit, a few past it
    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return LEN_W'($urandom_range(0, 4));
        end else if (r < 9) begin
            return LEN_W'($urandom_range(5, PAYLOAD_MAX));
        end
        return LEN_W'($urandom_range(PAYLOAD_MAX + 1, 63));
    endfunction

    // Present one transaction, with bursts of random length and random gaps
    task automatic send_item(input t_item item, input bit counted);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        action_count[item.action]++;
        if (counted) begin
            items_sent++;
        end
    endtask

    task automatic send_start(input logic [7:0] cmd, input logic [LEN_W-1:0] plen,
                              input logic [LEN_W-1:0] elen);
        t_item it;
        it                    = item_with(ACT_START, 8'($urandom));
        it.cmd_code           = cmd;
        it.payload_len        = plen;
        it.expected_reply_len = elen;
        send_item(it, 1'b1);
    endtask

    // Reply frame: start code, random address and id, length, confirm, data
    task automatic send_reply(input logic [15:0] len_field, input logic [7:0] conf,
                              input int nbytes);
        int         p;
        logic [7:0] value;
        for (p = 0; p < nbytes; p++) begin
            if (p == 0) begin
                value = START_HI;
            end else if (p == 1) begin
                value = START_LO;
            end else if (p == RX_POS_LEN_HI) begin
                value = len_field[15:8];
            end else if (p == RX_POS_LEN_LO) begin
                value = len_field[7:0];
            end else if (p == RX_POS_CONF) begin
                value = conf;
            end else begin
                value = 8'($urandom);
            end
            send_item(item_with(ACT_RX, value), 1'b1);
        end
    endtask

    // Hold input until every predicted result has left the block
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_address(input logic [31:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        addr_writes++;
    endtask

    // One command exchange, sometimes with noise, truncation or stray bytes
    task automatic run_command();
        logic [7:0]       cmd;
        logic [LEN_W-1:0] plen;
        logic [LEN_W-1:0] elen;
        logic [15:0]      len_field;
        logic [7:0]       conf;
        int               plen_n;
        int               elen_n;
        int               n_pay;
        int               n_reply;
        int               sel;

        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) send_item(noise_item(), 1'b0);
        end
        cmd    = 8'($urandom);
        plen   = pick_len();
        elen   = pick_len();
        plen_n = (plen > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(plen);
        elen_n = (elen > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(elen);
        send_start(cmd, plen, elen);

        n_pay = plen_n;
        if (n_pay > 0 && $urandom_range(0, 9) == 0) begin
            n_pay = $urandom_range(0, n_pay - 1);
        end
        repeat (n_pay) send_item(item_with(ACT_PAYLOAD, 8'($urandom)), 1'b1);

        sel = $urandom_range(0, 19);
        if (sel < 12) begin
            len_field = 16'(3 + $urandom_range(0, elen_n));
        end else if (sel < 14) begin
            len_field = 16'($urandom_range(0, 2));
        end else if (sel < 17) begin
            len_field = 16'(3 + elen_n + $urandom_range(1, 40));
        end else begin
            len_field = 16'($urandom);
        end
        conf = ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom);

        n_reply = 12 + elen_n;
        sel     = $urandom_range(0, 9);
        if (sel == 0) begin
            n_reply = 0;
        end else if (sel == 1) begin
            n_reply = $urandom_range(1, n_reply - 1);
        end else if (sel == 2) begin
            n_reply = n_reply + $urandom_range(1, 3);
        end
        send_reply(len_field, conf, n_reply);

        if ($urandom_range(0, 5) == 0) begin
            drain_results();
        end
    endtask

    initial begin
        logic [31:0] addr_set[PHASES];
        int          ph;
        int          phase_end;

        action_count = '{default: 0};
        addr_set[0]  = 32'h0000_0000;
        addr_set[1]  = $urandom;
        addr_set[2]  = 32'hFFFF_FFFF;
        addr_set[3]  = $urandom;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty payload, saturated lengths, restart mid-command,
        // ignored payload and unused action, then a well-formed reply
        send_start(8'h00, 6'd0, 6'd0);
        send_start(8'hFF, 6'd63, 6'd63);
        send_item(item_with(ACT_PAYLOAD, 8'hFF), 1'b1);
        send_item(item_with(ACT_PAYLOAD, 8'h00), 1'b1);
        send_start(8'hA5, 6'd1, 6'd2);
        send_item(item_with(ACT_PAYLOAD, 8'h80), 1'b1);
        send_item(item_with(ACT_PAYLOAD, 8'h55), 1'b0);
        send_item(item_with(ACT_UNUSED, 8'hFF), 1'b0);
        send_reply(16'd5, 8'h00, 14);

        // Random command exchanges under several module addresses
        phase_end = items_sent;
        for (ph = 0; ph < PHASES; ph++) begin
            write_address(addr_set[ph]);
            phase_end += ITEM_TARGET / PHASES;
            while (items_sent < phase_end) run_command();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d transactions: %0d start, %0d payload, %0d reply, %0d unused",
                 action_count[0] + action_count[1] + action_count[2] + action_count[3],
                 action_count[0], action_count[1], action_count[2], action_count[3]);
        $display("Checked %0d results across %0d address settings",
                 checked, addr_writes + 1);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
